// ===== rtl/core/spi_pkg.sv =====
`timescale 1ns / 1ps
package spi_pkg;

	// input and derived widths
	localparam int CB   = 12;           // coordinate bits
	localparam int FB   = 8;            // fraction bits of the result
	localparam int OB   = 24;           // result coordinate bits
	localparam int DB   = CB + 1;       // coordinate difference
	localparam int PB   = 2 * DB;       // product of two differences
	localparam int DETB = PB + 1;       // determinant and numerators
	localparam int NB   = CB + DETB + FB; // scaled dividend
	localparam int QB   = OB;           // quotient bits kept before saturation
	localparam int WB   = DETB + QB;    // divider working width
	localparam int VB   = OB + 2;       // rounded value before saturation

	localparam int QDEPTH = 4;
	localparam int QAW    = 2;

	localparam logic signed [VB-1:0] OUT_HI = VB'((1 <<< (OB - 1)) - 1);
	localparam logic signed [VB-1:0] OUT_LO = -OUT_HI - VB'(1);

	typedef struct packed {
		logic signed [CB-1:0] ax1;
		logic signed [CB-1:0] ay1;
		logic signed [CB-1:0] ax2;
		logic signed [CB-1:0] ay2;
		logic signed [CB-1:0] bx1;
		logic signed [CB-1:0] by1;
		logic signed [CB-1:0] bx2;
		logic signed [CB-1:0] by2;
	} spi_seg_t;

	// classified item handed from front to back
	typedef struct packed {
		logic                 par;
		logic                 oa;
		logic                 ob;
		logic                 negx;
		logic                 negy;
		logic signed [CB-1:0] basex;
		logic signed [CB-1:0] basey;
		logic [DETB-1:0]      d;
		logic [NB-1:0]        nx;
		logic [NB-1:0]        ny;
	} spi_mid_t;

	// divider stage contents
	typedef struct packed {
		logic                 par;
		logic                 oa;
		logic                 ob;
		logic                 negx;
		logic                 negy;
		logic                 bigx;
		logic                 bigy;
		logic signed [CB-1:0] basex;
		logic signed [CB-1:0] basey;
		logic [DETB-1:0]      d;
		logic [WB-1:0]        remx;
		logic [WB-1:0]        remy;
		logic [QB-1:0]        qx;
		logic [QB-1:0]        qy;
	} spi_div_t;

	typedef struct packed {
		logic [OB-1:0] val;
		logic          clip;
	} spi_coord_t;

	// one restoring step for quotient bit i
	function automatic spi_div_t spi_div_step(spi_div_t s, int unsigned i);
		logic [WB-1:0] sh;
		spi_div_t      r;
		sh = WB'(s.d) << i;
		r = s;
		if (s.remx >= sh) begin
			r.remx = s.remx - sh;
			r.qx = s.qx | (QB'(1) << i);
		end
		if (s.remy >= sh) begin
			r.remy = s.remy - sh;
			r.qy = s.qy | (QB'(1) << i);
		end
		return r;
	endfunction

	// round to nearest (ties up), add base, saturate
	function automatic spi_coord_t spi_coord(logic neg, logic big,
			logic signed [CB-1:0] base, logic [QB-1:0] q,
			logic [DETB-1:0] r, logic [DETB-1:0] d);
		logic [DETB:0]          r2;
		logic                   up;
		logic signed [VB-1:0]   mag;
		logic signed [VB-1:0]   v;
		spi_coord_t             res;
		r2 = {r, 1'b0};
		up = neg ? (r2 > {1'b0, d}) : (r2 >= {1'b0, d});
		mag = $signed(VB'(q)) + $signed(VB'(up));
		v = (VB'(base) <<< FB) + (neg ? -mag : mag);
		res.clip = 1'b0;
		res.val = v[OB-1:0];
		if (big) begin
			res.clip = 1'b1;
			res.val = neg ? OUT_LO[OB-1:0] : OUT_HI[OB-1:0];
		end else if (v > OUT_HI) begin
			res.clip = 1'b1;
			res.val = OUT_HI[OB-1:0];
		end else if (v < OUT_LO) begin
			res.clip = 1'b1;
			res.val = OUT_LO[OB-1:0];
		end
		return res;
	endfunction

endpackage

// ===== rtl/core/spi_front.sv =====
`timescale 1ns / 1ps
module spi_front (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              push,
	output logic              full,
	input  spi_pkg::spi_seg_t seg,
	output logic              mid_push,
	input  logic              mid_full,
	output spi_pkg::spi_mid_t mid
);
	import spi_pkg::*;

	logic en;
	logic v_s1, v_s2, v_s3, v_s4, v_s5;

	// stage 1: differences
	logic signed [DB-1:0] dxa_s1, dya_s1, dxb_s1, dyb_s1, ex_s1, ey_s1, dirx_s1, diry_s1;
	logic signed [CB-1:0] bx_s1, by_s1;
	// stage 2: products
	logic signed [PB-1:0] p1_s2, p2_s2, p3_s2, p4_s2, p5_s2, p6_s2;
	logic signed [DB-1:0] dirx_s2, diry_s2;
	logic signed [CB-1:0] bx_s2, by_s2;
	// stage 3: determinant and numerators
	logic signed [DETB-1:0] d_s3, tn_s3, un_s3;
	logic signed [DB-1:0]   dirx_s3, diry_s3;
	logic signed [CB-1:0]   bx_s3, by_s3;
	// stage 4: sign fix and classify
	logic                   par_s4, oa_s4, ob_s4, negx_s4, negy_s4;
	logic [DETB-1:0]        d_s4, mb_s4;
	logic [CB-1:0]          max_s4, may_s4;
	logic signed [CB-1:0]   bx_s4, by_s4;
	// stage 5: scaled dividends
	spi_mid_t               m_s5;

	logic signed [DETB-1:0] d_f, tn_f, un_f;
	logic signed [DB-1:0]   adx, ady;

	// stall only when the last stage cannot leave
	assign en   = !(v_s5 && mid_full);
	assign full = !en;

	always_comb begin
		d_f  = d_s3[DETB-1] ? -d_s3 : d_s3;
		tn_f = d_s3[DETB-1] ? -tn_s3 : tn_s3;
		un_f = d_s3[DETB-1] ? -un_s3 : un_s3;
		adx  = dirx_s3[DB-1] ? -dirx_s3 : dirx_s3;
		ady  = diry_s3[DB-1] ? -diry_s3 : diry_s3;
	end

	// valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
		end else if (en) begin
			v_s1 <= push;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
			v_s5 <= v_s4;
		end
	end

	// datapath
	always_ff @(posedge clk) begin
		if (en) begin
			dxa_s1  <= DB'(seg.ax1) - DB'(seg.ax2);
			dya_s1  <= DB'(seg.ay1) - DB'(seg.ay2);
			dxb_s1  <= DB'(seg.bx1) - DB'(seg.bx2);
			dyb_s1  <= DB'(seg.by1) - DB'(seg.by2);
			ex_s1   <= DB'(seg.ax1) - DB'(seg.bx1);
			ey_s1   <= DB'(seg.ay1) - DB'(seg.by1);
			dirx_s1 <= DB'(seg.ax2) - DB'(seg.ax1);
			diry_s1 <= DB'(seg.ay2) - DB'(seg.ay1);
			bx_s1   <= seg.ax1;
			by_s1   <= seg.ay1;

			p1_s2   <= dxa_s1 * dyb_s1;
			p2_s2   <= dya_s1 * dxb_s1;
			p3_s2   <= ex_s1 * dyb_s1;
			p4_s2   <= ey_s1 * dxb_s1;
			p5_s2   <= dya_s1 * ex_s1;
			p6_s2   <= dxa_s1 * ey_s1;
			dirx_s2 <= dirx_s1;
			diry_s2 <= diry_s1;
			bx_s2   <= bx_s1;
			by_s2   <= by_s1;

			d_s3    <= DETB'(p1_s2) - DETB'(p2_s2);
			tn_s3   <= DETB'(p3_s2) - DETB'(p4_s2);
			un_s3   <= DETB'(p5_s2) - DETB'(p6_s2);
			dirx_s3 <= dirx_s2;
			diry_s3 <= diry_s2;
			bx_s3   <= bx_s2;
			by_s3   <= by_s2;

			par_s4  <= (d_s3 == '0);
			oa_s4   <= !tn_f[DETB-1] && (tn_f <= d_f);
			ob_s4   <= !un_f[DETB-1] && (un_f <= d_f);
			negx_s4 <= dirx_s3[DB-1] != tn_f[DETB-1];
			negy_s4 <= diry_s3[DB-1] != tn_f[DETB-1];
			d_s4    <= d_f;
			mb_s4   <= tn_f[DETB-1] ? DETB'(-tn_f) : DETB'(tn_f);
			max_s4  <= adx[CB-1:0];
			may_s4  <= ady[CB-1:0];
			bx_s4   <= bx_s3;
			by_s4   <= by_s3;

			m_s5.par   <= par_s4;
			m_s5.oa    <= oa_s4;
			m_s5.ob    <= ob_s4;
			m_s5.negx  <= negx_s4;
			m_s5.negy  <= negy_s4;
			m_s5.basex <= bx_s4;
			m_s5.basey <= by_s4;
			m_s5.d     <= d_s4;
			m_s5.nx    <= NB'(max_s4 * mb_s4) << FB;
			m_s5.ny    <= NB'(may_s4 * mb_s4) << FB;
		end
	end

	assign mid_push = v_s5 && !mid_full;
	assign mid      = m_s5;

endmodule

// ===== rtl/core/spi_queue.sv =====
`timescale 1ns / 1ps
module spi_queue (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              push,
	output logic              full,
	input  spi_pkg::spi_mid_t din,
	input  logic              pop,
	output logic              empty,
	output spi_pkg::spi_mid_t dout
);
	import spi_pkg::*;

	spi_mid_t       mem_q [QDEPTH];
	logic [QAW-1:0] wptr_q, rptr_q;
	logic [QAW:0]   cnt_q;
	logic           do_push, do_pop;

	assign full    = (cnt_q == (QAW+1)'(QDEPTH));
	assign empty   = (cnt_q == '0);
	assign do_push = push && !full;
	assign do_pop  = pop && !empty;
	assign dout    = mem_q[rptr_q];

	// pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q <= '0;
			rptr_q <= '0;
			cnt_q  <= '0;
		end else begin
			if (do_push) wptr_q <= wptr_q + QAW'(1);
			if (do_pop) rptr_q <= rptr_q + QAW'(1);
			if (do_push && !do_pop) cnt_q <= cnt_q + (QAW+1)'(1);
			else if (do_pop && !do_push) cnt_q <= cnt_q - (QAW+1)'(1);
		end
	end

	// storage
	always_ff @(posedge clk) begin
		if (do_push) mem_q[wptr_q] <= din;
	end

endmodule

// ===== rtl/core/spi_back.sv =====
`timescale 1ns / 1ps
module spi_back (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 mid_empty,
	output logic                 mid_pop,
	input  spi_pkg::spi_mid_t    mid,
	output logic                 empty,
	input  logic                 pop,
	output logic [spi_pkg::OB-1:0] cross_x,
	output logic [spi_pkg::OB-1:0] cross_y,
	output logic                 on_a,
	output logic                 on_b,
	output logic                 hit,
	output logic                 parallel,
	output logic                 clipped
);
	import spi_pkg::*;

	logic       en;
	logic       v_s [QB+1];
	spi_div_t   st_s [QB+1];
	spi_div_t   first;
	spi_div_t   nxt [QB];
	spi_coord_t cx, cy;
	logic       ovalid_q;

	// whole divider advances when the output register frees
	assign en      = !ovalid_q || pop;
	assign mid_pop = en && !mid_empty;
	assign empty   = !ovalid_q;

	// saturation test and divider load
	always_comb begin
		first.par   = mid.par;
		first.oa    = mid.oa;
		first.ob    = mid.ob;
		first.negx  = mid.negx;
		first.negy  = mid.negy;
		first.basex = mid.basex;
		first.basey = mid.basey;
		first.d     = mid.d;
		first.remx  = WB'(mid.nx);
		first.remy  = WB'(mid.ny);
		first.bigx  = WB'(mid.nx) >= (WB'(mid.d) << QB);
		first.bigy  = WB'(mid.ny) >= (WB'(mid.d) << QB);
		first.qx    = '0;
		first.qy    = '0;
	end

	// one quotient bit per stage, msb first
	always_comb begin
		for (int k = 0; k < QB; k++) begin
			nxt[k] = spi_div_step(st_s[k], QB - 1 - k);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k <= QB; k++) v_s[k] <= 1'b0;
			ovalid_q <= 1'b0;
		end else if (en) begin
			v_s[0] <= !mid_empty;
			for (int k = 0; k < QB; k++) v_s[k+1] <= v_s[k];
			ovalid_q <= v_s[QB];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			st_s[0] <= first;
			for (int k = 0; k < QB; k++) st_s[k+1] <= nxt[k];
		end
	end

	// rounding and saturation
	always_comb begin
		cx = spi_coord(st_s[QB].negx, st_s[QB].bigx, st_s[QB].basex, st_s[QB].qx,
			st_s[QB].remx[DETB-1:0], st_s[QB].d);
		cy = spi_coord(st_s[QB].negy, st_s[QB].bigy, st_s[QB].basey, st_s[QB].qy,
			st_s[QB].remy[DETB-1:0], st_s[QB].d);
	end

	// output register
	always_ff @(posedge clk) begin
		if (en) begin
			if (st_s[QB].par) begin
				cross_x  <= '0;
				cross_y  <= '0;
				on_a     <= 1'b0;
				on_b     <= 1'b0;
				hit      <= 1'b0;
				parallel <= 1'b1;
				clipped  <= 1'b0;
			end else begin
				cross_x  <= cx.val;
				cross_y  <= cy.val;
				on_a     <= st_s[QB].oa;
				on_b     <= st_s[QB].ob;
				hit      <= st_s[QB].oa && st_s[QB].ob;
				parallel <= 1'b0;
				clipped  <= cx.clip || cy.clip;
			end
		end
	end

endmodule

// ===== rtl/core/segment_pair_intersection.sv =====
`timescale 1ns / 1ps
// Crossing point of two segments given by integer endpoints.
// Input channel: push / full with eight signed 12-bit endpoint coordinates;
// a beat is taken at a rising edge with push high and full low.
// Result channel: empty / pop; while empty is low the oldest result is on
// cross_x, cross_y (signed, 8 fraction bits, saturated), on_a, on_b, hit,
// parallel and clipped; a beat is taken at an edge with pop high.
// Throughput: one pair per cycle while the receiver pops results, with no dependence between items.
// Path from accept to result: five front
// stages (differences, six products, determinant, sign fix, scaling multiply),
// a queue entry, a saturation check stage, 24 divider stages of one
// restoring step each for both coordinates, and the output register.
// A four-entry queue separates the front from the divider pipeline. When the
// receiver stalls, the divider pipeline holds and the queue fills; full rises
// once the queue is full and a beat waits in the last front stage, and the
// whole front then holds.
// Reset (arst_n low) empties every stage and the queue; nothing else is kept.
module segment_pair_intersection (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        push,
	output logic                        full,
	input  logic signed [spi_pkg::CB-1:0] a_x1,
	input  logic signed [spi_pkg::CB-1:0] a_y1,
	input  logic signed [spi_pkg::CB-1:0] a_x2,
	input  logic signed [spi_pkg::CB-1:0] a_y2,
	input  logic signed [spi_pkg::CB-1:0] b_x1,
	input  logic signed [spi_pkg::CB-1:0] b_y1,
	input  logic signed [spi_pkg::CB-1:0] b_x2,
	input  logic signed [spi_pkg::CB-1:0] b_y2,
	output logic                        empty,
	input  logic                        pop,
	output logic signed [spi_pkg::OB-1:0] cross_x,
	output logic signed [spi_pkg::OB-1:0] cross_y,
	output logic                        on_a,
	output logic                        on_b,
	output logic                        hit,
	output logic                        parallel,
	output logic                        clipped
);
	import spi_pkg::*;

	spi_seg_t seg;
	spi_mid_t f_mid, q_mid;
	logic     f_push, q_full, q_empty, q_pop;
	logic [OB-1:0] cx, cy;

	assign seg = '{ax1: a_x1, ay1: a_y1, ax2: a_x2, ay2: a_y2,
		bx1: b_x1, by1: b_y1, bx2: b_x2, by2: b_y2};

	// front: differences, products, classification
	spi_front u_front (
		.clk(clk), .arst_n(arst_n), .push(push), .full(full), .seg(seg),
		.mid_push(f_push), .mid_full(q_full), .mid(f_mid)
	);

	// decoupling queue
	spi_queue u_queue (
		.clk(clk), .arst_n(arst_n), .push(f_push), .full(q_full), .din(f_mid),
		.pop(q_pop), .empty(q_empty), .dout(q_mid)
	);

	// back: division, rounding, output register
	spi_back u_back (
		.clk(clk), .arst_n(arst_n), .mid_empty(q_empty), .mid_pop(q_pop), .mid(q_mid),
		.empty(empty), .pop(pop), .cross_x(cx), .cross_y(cy), .on_a(on_a),
		.on_b(on_b), .hit(hit), .parallel(parallel), .clipped(clipped)
	);

	assign cross_x = $signed(cx);
	assign cross_y = $signed(cy);

endmodule
